// ----- hw/rtl/swa_pkg.sv -----
`default_nettype none
package swa_pkg;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [2:0] ST_SAMPLE  = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_LOADED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;

  localparam logic REG_MIN_TEMP = 1'b0;
  localparam logic REG_MAX_TEMP = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        sensor_key;
    logic [15:0]        room_id;
    logic signed [15:0] temperature;
  } swa_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        sensor_echo;
    logic [15:0]        room_out;
    logic signed [15:0] average;
    logic               too_cold;
    logic               too_hot;
  } swa_out_t;

  // Divider control bundle.
  typedef struct packed {
    logic start;
  } swa_div_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/swa_div.sv -----
`default_nettype none
// Restoring divider of a signed dividend by a positive count, one quotient bit
// per cycle, truncated toward zero.
module swa_div import swa_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire swa_div_ctl_t         ctl,
  input  wire logic signed [NW-1:0] dividend,
  input  wire logic [DW-1:0]        divisor,
  output logic                      done,
  output logic signed [NW-1:0]      quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [NW:0]   rem;
  logic [DW-1:0] dvs;
  logic          neg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW:0]   trial;
  logic [NW:0]   shifted;

  assign shifted = {rem[NW-1:0], quo[NW-1]};
  assign trial   = shifted - {{(NW+1-DW){1'b0}}, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        neg  <= dividend[NW-1];
        quo  <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[NW]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule
`default_nettype wire

// ----- hw/rtl/sensor_window_average_alarm.sv -----
`default_nettype none
// A sample for a known sensor is found by a linear scan of the table, pushed into its window,
// summed over the filled samples and divided; an unknown sample returns after the scan. A load
// scans, then moves each later entry and its window up; a duplicate or a load to a full table
// returns after the scan. One transaction at a time: in_stall stays high until the result is
// taken. Reset empties the table, thresholds 1500/2500.
module sensor_window_average_alarm import swa_pkg::*; #(
  parameter int MAX_SENSORS = 16,
  parameter int WINDOW_LEN  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire swa_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output swa_out_t         out_data
);
  localparam int EW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CW = $clog2(MAX_SENSORS + 1);
  localparam int WW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW = $clog2(WINDOW_LEN + 1);
  localparam int KW = $clog2(WINDOW_LEN + 3);
  localparam int MD = MAX_SENSORS * WINDOW_LEN;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;
  localparam int SW = 32;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_SHW    = 4'd4;
  localparam logic [3:0] S_INS    = 4'd5;
  localparam logic [3:0] S_PUSH   = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_WDIV   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state;
  logic signed [15:0] min_temp, max_temp;
  logic [CW-1:0] entry_count;
  logic [15:0] id_table [MAX_SENSORS];
  logic [15:0] room_table [MAX_SENSORS];
  logic [WW-1:0] window_head [MAX_SENSORS];
  logic [FW-1:0] window_fill [MAX_SENSORS];
  logic signed [15:0] win_mem [MD];

  swa_in_t item;
  logic [CW-1:0] idx, pos;
  logic found, pos_set;
  logic [FW-1:0] k;
  logic [KW-1:0] ck;
  logic [EW-1:0] ent;
  logic [WW-1:0] hd;
  logic [FW-1:0] fl;
  logic signed [SW-1:0] sum;
  logic signed [15:0] rd;
  logic [1:0] rd_ok;
  logic [MW-1:0] raddr, waddr;
  logic we;
  logic we_next;
  logic start_next;
  logic signed [15:0] wdata;
  swa_div_ctl_t dctl;
  logic ddone;
  logic signed [SW-1:0] quo;
  logic signed [15:0] avg;

  function automatic logic [MW-1:0] addr_of(input logic [EW-1:0] e, input logic [WW-1:0] s);
    return MW'(e) * MW'(WINDOW_LEN) + MW'(s);
  endfunction

  function automatic logic [WW-1:0] wrap(input logic [FW:0] v);
    logic [FW:0] r;
    r = v;
    if (r >= (FW+1)'(WINDOW_LEN)) r = r - (FW+1)'(WINDOW_LEN);
    return WW'(r);
  endfunction

  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (we) win_mem[waddr] <= wdata;
    rd <= win_mem[raddr];
  end

  swa_div #(.NW(SW), .DW(FW)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(sum), .divisor(fl),
    .done(ddone), .quotient(quo)
  );

  assign avg = quo[15:0];

  always_comb begin
    we_next    = 1'b0;
    start_next = 1'b0;
    case (state)
      S_PUSH: we_next = 1'b1;
      S_SHW: we_next = (ck >= KW'(2));
      S_DIV: start_next = 1'b1;
      default: we_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      min_temp    <= 16'sd1500;
      max_temp    <= 16'sd2500;
      entry_count <= '0;
      out_valid   <= 1'b0;
      we          <= 1'b0;
      dctl.start  <= 1'b0;
      rd_ok       <= '0;
    end else begin
      we         <= we_next;
      dctl.start <= start_next;
      if (cfg_we) begin
        if (cfg_index == REG_MIN_TEMP) min_temp <= $signed(cfg_data);
        else max_temp <= $signed(cfg_data);
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item    <= in_data;
            idx     <= '0;
            found   <= 1'b0;
            pos     <= entry_count;
            pos_set <= 1'b0;
            state   <= S_SRCH;
          end
        end
        // Linear scan: exact match and the sorted insertion point.
        S_SRCH: begin
          if (idx == entry_count || found) begin
            state <= S_DEC;
          end else begin
            if (id_table[EW'(idx)] == item.sensor_key) begin
              found <= 1'b1;
              ent   <= EW'(idx);
            end
            if (!pos_set && !(id_table[EW'(idx)] < item.sensor_key)) begin
              pos     <= idx;
              pos_set <= 1'b1;
            end
            idx <= idx + 1'b1;
          end
        end
        S_DEC: begin
          out_data.sensor_echo <= item.sensor_key;
          out_data.room_out    <= '0;
          out_data.average     <= '0;
          out_data.too_cold    <= 1'b0;
          out_data.too_hot     <= 1'b0;
          if (item.cmd == CMD_LOAD) begin
            if (found) begin
              out_data.status <= ST_DUP;
              state <= S_OUT;
            end else if (entry_count == CW'(MAX_SENSORS)) begin
              out_data.status <= ST_FULL;
              state <= S_OUT;
            end else begin
              idx   <= entry_count;
              state <= S_SHIFT;
            end
          end else if (!found) begin
            out_data.status <= ST_UNKNOWN;
            state <= S_OUT;
          end else begin
            hd    <= window_head[ent];
            fl    <= window_fill[ent];
            state <= S_PUSH;
          end
        end
        // Move entry idx-1 up to idx, its window one sample a cycle.
        S_SHIFT: begin
          if (idx == pos) begin
            state <= S_INS;
          end else begin
            id_table[EW'(idx)]    <= id_table[EW'(idx - 1'b1)];
            room_table[EW'(idx)]  <= room_table[EW'(idx - 1'b1)];
            window_head[EW'(idx)] <= window_head[EW'(idx - 1'b1)];
            window_fill[EW'(idx)] <= window_fill[EW'(idx - 1'b1)];
            ck    <= '0;
            state <= S_SHW;
          end
        end
        // Read data passes through the raddr and rd registers, so each write trails its read.
        S_SHW: begin
          if (ck < KW'(WINDOW_LEN)) raddr <= addr_of(EW'(idx - 1'b1), WW'(ck));
          if (ck >= KW'(2)) begin
            waddr <= addr_of(EW'(idx), WW'(ck - KW'(2)));
            wdata <= rd;
          end
          if (ck == KW'(WINDOW_LEN + 1)) begin
            idx   <= idx - 1'b1;
            state <= S_SHIFT;
          end else begin
            ck <= ck + 1'b1;
          end
        end
        S_INS: begin
          id_table[EW'(pos)]    <= item.sensor_key;
          room_table[EW'(pos)]  <= item.room_id;
          window_head[EW'(pos)] <= '0;
          window_fill[EW'(pos)] <= '0;
          entry_count           <= entry_count + 1'b1;
          out_data.status       <= ST_LOADED;
          out_data.room_out     <= item.room_id;
          state                 <= S_OUT;
        end
        S_PUSH: begin
          wdata <= item.temperature;
          if (fl == FW'(WINDOW_LEN)) begin
            waddr <= addr_of(ent, hd);
            hd    <= wrap({1'b0, FW'(hd)} + 1'b1);
            window_head[ent] <= wrap({1'b0, FW'(hd)} + 1'b1);
          end else begin
            waddr <= addr_of(ent, wrap({1'b0, FW'(hd)} + {1'b0, fl}));
            fl    <= fl + 1'b1;
            window_fill[ent] <= fl + 1'b1;
          end
          sum   <= '0;
          k     <= '0;
          rd_ok <= '0;
          state <= S_SUM;
        end
        // One read and one add per cycle; read data lands through the raddr and rd registers.
        S_SUM: begin
          if (rd_ok[1]) sum <= sum + SW'(rd);
          if (k == fl) begin
            rd_ok <= {rd_ok[0], 1'b0};
            if (rd_ok == 2'b00) state <= S_DIV;
          end else begin
            raddr <= addr_of(ent, wrap({1'b0, FW'(hd)} + {1'b0, k}));
            k     <= k + 1'b1;
            rd_ok <= {rd_ok[0], 1'b1};
          end
        end
        S_DIV: begin
          state <= S_WDIV;
        end
        S_WDIV: begin
          if (ddone) begin
            out_data.status   <= ST_SAMPLE;
            out_data.room_out <= room_table[ent];
            out_data.average  <= avg;
            out_data.too_cold <= avg < min_temp;
            out_data.too_hot  <= avg > max_temp;
            state             <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) entry_count <= CW'(MAX_SENSORS))
    else $error("entry count overflow");
  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> in_stall)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid && state == S_IDLE)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");
endmodule
`default_nettype wire

// ----- tb/sv/swa_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module swa_checker import swa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic     cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire swa_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire swa_out_t out_data,
  output int            errors,
  output int            pending
);

  localparam int NSENS = 16;
  localparam int WLEN  = 8;

  int unsigned        n_entries;
  logic [15:0]        ids [NSENS];
  logic [15:0]        rooms [NSENS];
  logic signed [15:0] windows [NSENS][WLEN];
  int unsigned        heads [NSENS];
  int unsigned        fills [NSENS];
  logic signed [15:0] lo_limit;
  logic signed [15:0] hi_limit;
  swa_out_t           expected_results [$];

  assign pending = expected_results.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic swa_out_t average_item(input swa_in_t it);
    swa_out_t r;
    int e, pos, k, sum, avg;
    r = '0;
    r.sensor_echo = it.sensor_key;
    e = -1;
    for (k = 0; k < n_entries; k++) if (ids[k] == it.sensor_key) e = k;
    if (it.cmd == CMD_LOAD) begin
      if (e >= 0) begin
        r.status = ST_DUP;
      end else if (n_entries >= NSENS) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < n_entries && ids[pos] < it.sensor_key) pos++;
        for (k = n_entries; k > pos; k--) begin
          ids[k] = ids[k-1];
          rooms[k] = rooms[k-1];
          windows[k] = windows[k-1];
          heads[k] = heads[k-1];
          fills[k] = fills[k-1];
        end
        ids[pos] = it.sensor_key;
        rooms[pos] = it.room_id;
        heads[pos] = 0;
        fills[pos] = 0;
        n_entries++;
        r.status = ST_LOADED;
        r.room_out = it.room_id;
      end
    end else if (e < 0) begin
      r.status = ST_UNKNOWN;
    end else begin
      if (fills[e] >= WLEN) begin
        windows[e][heads[e]] = it.temperature;
        heads[e] = (heads[e] + 1) % WLEN;
      end else begin
        windows[e][(heads[e] + fills[e]) % WLEN] = it.temperature;
        fills[e]++;
      end
      sum = 0;
      for (k = 0; k < fills[e]; k++) sum += windows[e][(heads[e] + k) % WLEN];
      avg = sum / int'(fills[e]);
      r.status = ST_SAMPLE;
      r.room_out = rooms[e];
      r.average = avg[15:0];
      r.too_cold = avg < int'(lo_limit);
      r.too_hot = avg > int'(hi_limit);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    swa_out_t want;
    if (rst) begin
      n_entries = 0;
      lo_limit = 16'sd1500;
      hi_limit = 16'sd2500;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MIN_TEMP) lo_limit = cfg_data;
        else hi_limit = cfg_data;
      end
      if (in_valid && !in_stall) expected_results.push_back(average_item(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 32'(out_data.sensor_echo), 32'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status != want.status)
            report("status", 32'(out_data.status), 32'(want.status));
          if (out_data.sensor_echo != want.sensor_echo)
            report("sensor_echo", 32'(out_data.sensor_echo), 32'(want.sensor_echo));
          if (out_data.room_out != want.room_out)
            report("room_out", 32'(out_data.room_out), 32'(want.room_out));
          if (out_data.average != want.average)
            report("average", 32'(out_data.average), 32'(want.average));
          if (out_data.too_cold != want.too_cold)
            report("too_cold", 32'(out_data.too_cold), 32'(want.too_cold));
          if (out_data.too_hot != want.too_hot)
            report("too_hot", 32'(out_data.too_hot), 32'(want.too_hot));
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench import swa_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_MIN_TEMP;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  swa_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  swa_out_t    out_data;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  bit          quiet_tail = 0;
  bit          hold_off = 0;
  logic [15:0] known_ids [$];

  always #1 clk = ~clk;

  sensor_window_average_alarm DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  swa_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // Receiver: random stall bursts, or a long hold-off when asked.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        for (n = 0; n < 600; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 0;
        @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(input logic cmd, input logic [15:0] sid, input logic [15:0] rid,
                      input logic [15:0] temp);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: cmd, sensor_key: sid, room_id: rid, temperature: temp};
    if (cmd == CMD_LOAD) known_ids.push_back(sid);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_TEMP;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_TEMP;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_id();
    if (known_ids.size() != 0 && $urandom_range(0, 9) != 0)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    return 16'($urandom);
  endfunction

  initial begin
    int i, phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unknown sensor, extreme ids, full window at extreme temperatures, duplicate.
    send(CMD_SAMPLE, 16'h1234, 16'hffff, 16'h7fff);
    send(CMD_LOAD, 16'hffff, 16'hffff, 16'h0000);
    send(CMD_LOAD, 16'h0000, 16'h0000, 16'hffff);
    send(CMD_LOAD, 16'h8000, 16'h5a5a, 16'h0000);
    send(CMD_LOAD, 16'h8000, 16'h1111, 16'h0000);
    for (i = 0; i < 9; i++) send(CMD_SAMPLE, 16'hffff, 16'h0, 16'h7fff);
    for (i = 0; i < 9; i++) send(CMD_SAMPLE, 16'h0000, 16'h0, 16'h8000);
    send(CMD_SAMPLE, 16'h8000, 16'h0, 16'd1499);
    send(CMD_SAMPLE, 16'h8000, 16'h0, 16'd3501);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      rst <= 1'b0;
      case (phase)
        0: set_limits(16'h8000, 16'h7fff);
        1: set_limits(16'h7fff, 16'h8000);
        2: set_limits(16'hfc18, 16'd1000);
        default: set_limits(16'($urandom), 16'($urandom));
      endcase
      if (phase == 5) quiet_tail = 1;
      // Fill the table up past capacity with inserts at random positions.
      if (phase == 0) begin
        while (known_ids.size() < 20) send(CMD_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
        hold_off = 1;
      end
      for (i = 0; i < 200; i++) begin
        if ($urandom_range(0, 9) == 0)
          send(CMD_LOAD, pick_id(), 16'($urandom), 16'($urandom));
        else
          send(CMD_SAMPLE, pick_id(), 16'($urandom), $urandom_range(0, 1) ?
               16'($urandom) : 16'($urandom_range(0, 4000)));
      end
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
